@@ src/cbsa_pkg.sv @@
package cbsa_pkg;

  // Converter and accumulator widths.
  localparam int ADC_BITS = 16;
  localparam int ADC_W    = 16;
  localparam int SUM_W    = 19;
  localparam int AVG_W    = 16;
  localparam int POS_W    = 5;
  localparam int STEP_W   = 4;
  localparam int PHASE_W  = 2;
  localparam int WORD_W   = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CHOPPER_STEPS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOPPER_FORWARD = 1'd1;
  localparam logic [STEP_W-1:0]    STEPS_RESET         = 4'd6;
  localparam logic [STEP_W-1:0]    MAX_STEPS           = 4'd8;

  // Request codes.
  localparam logic [1:0] REQ_TRIGGER     = 2'd0;
  localparam logic [1:0] REQ_RESTART     = 2'd1;
  localparam logic [1:0] REQ_RESTART_LOW = 2'd2;

  // Cycle positions.
  localparam logic [POS_W-1:0] POS_BEAM_LOW  = 5'd1;
  localparam logic [POS_W-1:0] POS_S_FIRST   = 5'd7;
  localparam logic [POS_W-1:0] POS_S_LAST    = 5'd11;
  localparam logic [POS_W-1:0] POS_MOTOR_A   = 5'd12;
  localparam logic [POS_W-1:0] POS_BEAM_HIGH = 5'd13;
  localparam logic [POS_W-1:0] POS_R_FIRST   = 5'd19;
  localparam logic [POS_W-1:0] POS_R_LAST    = 5'd23;
  localparam logic [POS_W-1:0] CYCLE_LEN     = 5'd24;

  // Divide by five: x * ceil(2^22 / 5) >> 22 is exact for every 19-bit x.
  localparam int AVG_DIV      = 5;
  localparam int RECIP_SHIFT  = 22;
  localparam int RECIP_W      = 20;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + AVG_DIV - 1) / AVG_DIV);

  // Coil bytes of the four motor phases.
  localparam logic [7:0] COIL_B_F8 = 8'hF8;
  localparam logic [7:0] COIL_B_08 = 8'h08;
  localparam logic [7:0] COIL_B_02 = 8'h02;
  localparam logic [7:0] COIL_B_E8 = 8'hE8;
  localparam logic [7:0] COIL_B_B8 = 8'hB8;
  localparam logic [7:0] COIL_B_03 = 8'h03;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified item, as handed from the front to the back.
  typedef struct packed {
    logic               beam;
    logic               sample_upd;
    logic               reference_upd;
    logic               motor;
    logic [STEP_W-1:0]  steps;
    logic [POS_W-1:0]   pos;
    logic [SUM_W-1:0]   avg_sum;
  } job_t;

  function automatic logic [WORD_W-1:0] coil_word(input logic [PHASE_W-1:0] phase);
    logic [WORD_W-1:0] w;
    case (phase)
      2'd0:    w = {COIL_B_F8, COIL_B_08};
      2'd1:    w = {COIL_B_02, COIL_B_E8};
      2'd2:    w = {COIL_B_B8, COIL_B_08};
      2'd3:    w = {COIL_B_03, COIL_B_E8};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ src/cbsa_if.sv @@
interface cbsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] adc_word;

  modport source (output valid, output req_type, output adc_word, input ready);
  modport sink   (input valid, input req_type, input adc_word, output ready);
endinterface

interface cbsa_out_if;
  logic        valid;
  logic        ready;
  logic        beam_select;
  logic        drive_valid;
  logic [15:0] drive_word;
  logic [15:0] sample_average;
  logic [15:0] reference_average;
  logic        sample_updated;
  logic        reference_updated;
  logic [4:0]  cycle_position;
  logic        last;

  modport source (output valid, output beam_select, output drive_valid, output drive_word,
                  output sample_average, output reference_average, output sample_updated,
                  output reference_updated, output cycle_position, output last,
                  input ready);
  modport sink   (input valid, input beam_select, input drive_valid, input drive_word,
                  input sample_average, input reference_average, input sample_updated,
                  input reference_updated, input cycle_position, input last,
                  output ready);
endinterface

@@ src/cbsa_front.sv @@
module cbsa_front (
  input  logic                            clk,
  input  logic                            rst_n,
  cbsa_in_if.sink                         in_ch,
  input  logic                            cfg_we,
  input  logic [cbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbsa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_full,
  output logic                            push,
  output cbsa_pkg::job_t                  job,
  output logic                            chopper_forward
);
  import cbsa_pkg::*;

  logic [POS_W-1:0]  cycle_r, cycle_nxt;
  logic [SUM_W-1:0]  ssum_r, ssum_nxt;
  logic [SUM_W-1:0]  rsum_r, rsum_nxt;
  logic              beam_r, beam_nxt;
  logic [STEP_W-1:0] steps_r;
  logic              fwd_r;
  logic [POS_W-1:0]  pos;
  logic [SUM_W-1:0]  word_ext;
  logic [SUM_W-1:0]  ssum_add, rsum_add;
  logic              accept;

  assign in_ch.ready     = !q_full;
  assign accept          = in_ch.valid && !q_full;
  assign push            = accept;
  assign chopper_forward = fwd_r;

  assign pos      = cycle_r + POS_W'(1);
  assign word_ext = SUM_W'(in_ch.adc_word[ADC_BITS-1:0]);
  assign ssum_add = ssum_r + word_ext;
  assign rsum_add = rsum_r + word_ext;

  always_comb begin
    cycle_nxt         = cycle_r;
    ssum_nxt          = ssum_r;
    rsum_nxt          = rsum_r;
    beam_nxt          = beam_r;
    job.sample_upd    = 1'b0;
    job.reference_upd = 1'b0;
    job.motor         = 1'b0;
    job.steps         = (steps_r > MAX_STEPS) ? MAX_STEPS : steps_r;
    job.avg_sum       = ssum_add;
    case (in_ch.req_type)
      REQ_RESTART: begin
        cycle_nxt = '0;
      end
      REQ_RESTART_LOW: begin
        cycle_nxt = '0;
        beam_nxt  = 1'b0;
      end
      REQ_TRIGGER: begin
        cycle_nxt = pos;
        if (pos == POS_BEAM_LOW) begin
          beam_nxt = 1'b0;
        end else if (pos == POS_BEAM_HIGH) begin
          beam_nxt = 1'b1;
        end else if (pos >= POS_S_FIRST && pos <= POS_S_LAST) begin
          ssum_nxt = ssum_add;
          if (pos == POS_S_LAST) begin
            ssum_nxt       = '0;
            job.sample_upd = 1'b1;
          end
        end else if (pos >= POS_R_FIRST && pos <= POS_R_LAST) begin
          rsum_nxt    = rsum_add;
          job.avg_sum = rsum_add;
          if (pos == POS_R_LAST) begin
            rsum_nxt          = '0;
            job.reference_upd = 1'b1;
          end
        end else if (pos == POS_MOTOR_A || pos >= CYCLE_LEN) begin
          job.motor = 1'b1;
          if (pos >= CYCLE_LEN) begin
            cycle_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
    job.beam = beam_nxt;
    job.pos  = cycle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r <= '0;
      ssum_r  <= '0;
      rsum_r  <= '0;
      beam_r  <= 1'b0;
      steps_r <= STEPS_RESET;
      fwd_r   <= 1'b1;
    end else begin
      if (accept) begin
        cycle_r <= cycle_nxt;
        ssum_r  <= ssum_nxt;
        rsum_r  <= rsum_nxt;
        beam_r  <= beam_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHOPPER_STEPS:   steps_r <= STEP_W'(cfg_data);
          REG_CHOPPER_FORWARD: fwd_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ src/cbsa_queue.sv @@
module cbsa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbsa_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cbsa_pkg::job_t head_job
);
  import cbsa_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (wr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + Q_PTR_W'(1);
      end
    end
  end

endmodule

@@ src/cbsa_back.sv @@
module cbsa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  cbsa_pkg::job_t head_job,
  input  logic           chopper_forward,
  output logic           pop,
  cbsa_out_if.source     out_ch
);
  import cbsa_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  logic               out_valid_r;
  logic               beam_r, dv_r, su_r, ru_r, last_r;
  logic [WORD_W-1:0]  dword_r;
  logic [AVG_W-1:0]   savg_r, savg_nxt;
  logic [AVG_W-1:0]   ravg_r, ravg_nxt;
  logic [POS_W-1:0]   pos_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [AVG_W-1:0]   avg;
  logic               can_load, fire, drive, is_final;

  assign prod = PROD_W'(head_job.avg_sum) * PROD_W'(AVG_RECIP);
  assign quot = prod[PROD_W-1:RECIP_SHIFT];
  assign avg  = (quot > QUOT_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}} : quot[AVG_W-1:0];

  assign can_load = !out_valid_r || out_ch.ready;
  assign fire     = can_load && head_valid;
  assign drive    = head_job.motor && (head_job.steps != '0);
  assign is_final = !drive || ((step_r + STEP_W'(1)) == head_job.steps);
  assign pop      = fire && is_final;
  assign step_nxt = is_final ? '0 : step_r + STEP_W'(1);

  assign phase_nxt = chopper_forward ? phase_r + PHASE_W'(1) : phase_r - PHASE_W'(1);
  assign savg_nxt  = head_job.sample_upd ? avg : savg_r;
  assign ravg_nxt  = head_job.reference_upd ? avg : ravg_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      beam_r  <= head_job.beam;
      dv_r    <= drive;
      dword_r <= drive ? coil_word(phase_nxt) : '0;
      su_r    <= head_job.sample_upd;
      ru_r    <= head_job.reference_upd;
      pos_r   <= head_job.pos;
      last_r  <= is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      step_r      <= '0;
      savg_r      <= '0;
      ravg_r      <= '0;
    end else begin
      if (can_load) begin
        out_valid_r <= head_valid;
      end
      if (fire) begin
        step_r <= step_nxt;
        savg_r <= savg_nxt;
        ravg_r <= ravg_nxt;
        if (drive) begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.beam_select       = beam_r;
  assign out_ch.drive_valid       = dv_r;
  assign out_ch.drive_word        = dword_r;
  assign out_ch.sample_average    = savg_r;
  assign out_ch.reference_average = ravg_r;
  assign out_ch.sample_updated    = su_r;
  assign out_ch.reference_updated = ru_r;
  assign out_ch.cycle_position    = pos_r;
  assign out_ch.last              = last_r;

endmodule

@@ src/chopper_beam_sequencer_averager.sv @@
// Channel   Dir  Beat contents
// in_ch     in   req_type, adc_word: one trigger or restart command
// out_ch    out  beam_select, drive_valid, drive_word, sample_average,
//                reference_average, sample_updated, reference_updated,
//                cycle_position, last: one result, last set on an item's final one
// cfg_*     in   write enable, register index, write data (no read-back)
//
// Every item that is not a motor position yields one result beat; a motor position
// (12 and 24) yields one beat per drive word, so up to eight, or one plain beat at
// zero steps. The result stage issues one beat per cycle while the output is ready.
// Reset is synchronous and active low; it clears positions, sums, averages,
// beam level, motor phase and the queue, and loads the register defaults.
// Input and output stall independently through the two-entry queue.
module chopper_beam_sequencer_averager (
  input  logic                            clk,
  input  logic                            rst_n,
  cbsa_in_if.sink                         in_ch,
  cbsa_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbsa_pkg::*;

  // The front classifies each accepted beat, updates the position, the beam
  // level and the running sums at once, and queues a job. The back turns
  // each job into result beats and owns the motor phase and the averages.
  logic push, q_full, pop, head_valid, fwd;
  job_t push_job, head_job;

  cbsa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .push            (push),
    .job             (push_job),
    .chopper_forward (fwd)
  );

  // Short queue that lets the front keep accepting while a motor position
  // is still emitting its drive words.
  cbsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back holds the head job until its last beat is loaded into the
  // output register; averages are divided by five there with one multiply.
  cbsa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .chopper_forward (fwd),
    .pop             (pop),
    .out_ch          (out_ch)
  );

endmodule

@@ src/cbsa_checker.sv @@
module cbsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        drive_valid,
  input logic [15:0] drive_word,
  input logic        sample_updated,
  input logic        reference_updated,
  input logic [4:0]  cycle_position,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive_word) && $stable(last))
    else $error("result beat changed while stalled");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !drive_valid |-> last && (drive_word == 16'd0))
    else $error("result without drive word is not a single final beat");

  a_update_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (sample_updated || reference_updated) |->
      !drive_valid && !(sample_updated && reference_updated))
    else $error("average update mixed with a motor step or the other beam");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cycle_position < 5'd24)
    else $error("cycle position out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind chopper_beam_sequencer_averager cbsa_checker u_cbsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .drive_valid       (out_ch.drive_valid),
  .drive_word        (out_ch.drive_word),
  .sample_updated    (out_ch.sample_updated),
  .reference_updated (out_ch.reference_updated),
  .cycle_position    (out_ch.cycle_position),
  .last              (out_ch.last)
);

@@ dv/cbsa_tb_pkg.sv @@
`timescale 1ns / 1ps

package cbsa_tb_pkg;
  import cbsa_pkg::*;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic               beam_select;
    logic               drive_valid;
    logic [WORD_W-1:0]  drive_word;
    logic [AVG_W-1:0]   sample_average;
    logic [AVG_W-1:0]   reference_average;
    logic               sample_updated;
    logic               reference_updated;
    logic [POS_W-1:0]   cycle_position;
    logic               last;
  } chopper_beat_t;

  class chopper_tracker;
    logic [STEP_W-1:0]  step_setting;
    logic               forward_setting;
    logic [POS_W-1:0]   position;
    logic [SUM_W-1:0]   sample_acc;
    logic [SUM_W-1:0]   reference_acc;
    logic [AVG_W-1:0]   sample_avg;
    logic [AVG_W-1:0]   reference_avg;
    logic               beam;
    logic [PHASE_W-1:0] phase;
    logic [WORD_W-1:0]  coil_lut [4];
    chopper_beat_t      awaited [$];
    int requests;
    int beats;
    int drive_words;
    int sample_avgs;
    int reference_avgs;
    int clipped_avgs;
    int errors;

    function new();
      coil_lut[0]     = 16'hF808;
      coil_lut[1]     = 16'h02E8;
      coil_lut[2]     = 16'hB808;
      coil_lut[3]     = 16'h03E8;
      step_setting    = STEPS_RESET;
      forward_setting = 1'b1;
      position        = '0;
      sample_acc      = '0;
      reference_acc   = '0;
      sample_avg      = '0;
      reference_avg   = '0;
      beam            = 1'b0;
      phase           = '0;
      requests        = 0;
      beats           = 0;
      drive_words     = 0;
      sample_avgs     = 0;
      reference_avgs  = 0;
      clipped_avgs    = 0;
      errors          = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHOPPER_STEPS) begin
        step_setting = data;
      end else if (idx == REG_CHOPPER_FORWARD) begin
        forward_setting = data[0];
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Sum over one five-position window divided by five, clipped to full scale.
    function logic [AVG_W-1:0] averaged(logic [SUM_W-1:0] total);
      int unsigned quotient;
      quotient = total / AVG_DIV;
      if (quotient > 32'h0000_FFFF) begin
        clipped_avgs++;
        return '1;
      end
      return quotient[AVG_W-1:0];
    endfunction

    function void queue_beat(logic dv, logic [WORD_W-1:0] dw, logic su, logic ru, logic lst);
      chopper_beat_t b;
      b.beam_select       = beam;
      b.drive_valid       = dv;
      b.drive_word        = dw;
      b.sample_average    = sample_avg;
      b.reference_average = reference_avg;
      b.sample_updated    = su;
      b.reference_updated = ru;
      b.cycle_position    = position;
      b.last              = lst;
      awaited.push_back(b);
    endfunction

    function void note_request(logic [1:0] req, logic [ADC_W-1:0] word);
      logic [POS_W-1:0]  next_pos;
      logic [STEP_W-1:0] n_steps;
      logic              su;
      logic              ru;
      int                k;
      su = 1'b0;
      ru = 1'b0;
      requests++;
      if (req == REQ_RESTART || req == REQ_RESTART_LOW) begin
        position = '0;
        if (req == REQ_RESTART_LOW) beam = 1'b0;
        queue_beat(1'b0, '0, 1'b0, 1'b0, 1'b1);
        return;
      end
      if (req != REQ_TRIGGER) begin
        queue_beat(1'b0, '0, 1'b0, 1'b0, 1'b1);
        return;
      end
      next_pos = position + 1'b1;
      position = next_pos;
      if (next_pos == POS_BEAM_LOW) begin
        beam = 1'b0;
      end else if (next_pos == POS_BEAM_HIGH) begin
        beam = 1'b1;
      end else if (next_pos >= POS_S_FIRST && next_pos <= POS_S_LAST) begin
        sample_acc = sample_acc + SUM_W'(word);
        if (next_pos == POS_S_LAST) begin
          sample_avg = averaged(sample_acc);
          sample_acc = '0;
          su         = 1'b1;
          sample_avgs++;
        end
      end else if (next_pos >= POS_R_FIRST && next_pos <= POS_R_LAST) begin
        reference_acc = reference_acc + SUM_W'(word);
        if (next_pos == POS_R_LAST) begin
          reference_avg = averaged(reference_acc);
          reference_acc = '0;
          ru            = 1'b1;
          reference_avgs++;
        end
      end else if (next_pos == POS_MOTOR_A || next_pos >= CYCLE_LEN) begin
        if (next_pos >= CYCLE_LEN) position = '0;
        n_steps = (step_setting > MAX_STEPS) ? MAX_STEPS : step_setting;
        if (n_steps == 0) begin
          queue_beat(1'b0, '0, 1'b0, 1'b0, 1'b1);
          return;
        end
        for (k = 0; k < int'(n_steps); k++) begin
          phase = forward_setting ? phase + 1'b1 : phase - 1'b1;
          drive_words++;
          queue_beat(1'b1, coil_lut[phase], 1'b0, 1'b0, k == int'(n_steps) - 1);
        end
        return;
      end
      queue_beat(1'b0, '0, su, ru, 1'b1);
    endfunction

    function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v,
                 got_v);
      end
    endfunction

    function void check_beat(chopper_beat_t got);
      chopper_beat_t want;
      beats++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("beam_select", want.beam_select, got.beam_select);
      compare_field("drive_valid", want.drive_valid, got.drive_valid);
      compare_field("drive_word", want.drive_word, got.drive_word);
      compare_field("sample_average", want.sample_average, got.sample_average);
      compare_field("reference_average", want.reference_average, got.reference_average);
      compare_field("sample_updated", want.sample_updated, got.sample_updated);
      compare_field("reference_updated", want.reference_updated, got.reference_updated);
      compare_field("cycle_position", want.cycle_position, got.cycle_position);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Checks the chopper sequencer against a cycle-position tracker that runs
// alongside it. Every accepted request beat is handed to the tracker, which
// queues the result beats the block owes; every accepted result beat is then
// compared field by field with the oldest one still owed.
module testbench;
  import cbsa_pkg::*;
  import cbsa_tb_pkg::*;

  // A quiet stretch longer than this means the block has hung. The longest
  // legal one is the forced output hold-off plus a long random stall.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  // Slack after the last owed beat, well above what a motor position needs for
  // its eight drive words, so that any stray extra beat is still caught.
  localparam int SETTLE_CYCLES   = 32;
  localparam int RANDOM_ITEMS    = 80;
  localparam int PHASES          = 5;
  localparam logic [ADC_W-1:0] FULL_SCALE = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cbsa_in_if  in_ch ();
  cbsa_out_if out_ch ();

  chopper_tracker tracker = new();
  chopper_beat_t  seen;

  bit tx_no_gaps   = 1'b0;
  bit hold_off_req = 1'b0;
  int stall_left   = 0;
  int steady_left  = 0;
  int rx_pick      = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int settings     = 0;

  chopper_beam_sequencer_averager i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Converter words lean toward the extremes, since full-scale words are what
  // drive the window sums into wrap and the averages into clipping.
  function automatic logic [ADC_W-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 20) return FULL_SCALE;
    if (r < 30) return '0;
    if (r < 40) return ADC_W'(1) << $urandom_range(ADC_W - 1);
    return ADC_W'($urandom);
  endfunction

  // Optional idle time before a request. Mostly none or a short gap, now and
  // then a long gap, and none at all while a burst is running.
  task automatic tx_gap();
    int r;
    int n;
    r = $urandom_range(99);
    if (tx_no_gaps || r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one request beat and returns at the edge that accepts it. Valid is
  // left high so that back-to-back beats never lower and raise it in one step.
  task automatic send_item(logic [1:0] req, logic [ADC_W-1:0] word);
    tx_gap();
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.adc_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(req, word);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result beat has arrived; the
  // watchdog bounds the wait.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  // of a group, so that back-to-back writes never drop and raise it at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_register(idx, data);
  endtask

  // Packs more than five full-scale words into one averaging window: walk up
  // to the position just before the window closes, restart, and walk through
  // the whole window again. The sum then wraps or the average clips.
  task automatic stuff_window();
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] close_pos;
    if (tracker.position >= POS_R_LAST) send_item(REQ_TRIGGER, pick_word());
    if (tracker.position < POS_S_LAST) begin
      first_pos = POS_S_FIRST;
      close_pos = POS_S_LAST;
    end else begin
      first_pos = POS_R_FIRST;
      close_pos = POS_R_LAST;
    end
    while (tracker.position != close_pos - 1'b1) begin
      send_item(REQ_TRIGGER,
                (tracker.position + 1'b1 >= first_pos) ? FULL_SCALE : pick_word());
    end
    send_item($urandom_range(1) ? REQ_RESTART : REQ_RESTART_LOW, pick_word());
    while (tracker.position != close_pos) send_item(REQ_TRIGGER, FULL_SCALE);
  endtask

  // Random traffic is mostly runs of triggers, so that the cycle keeps
  // reaching the windows and motor positions, broken up by restarts, the
  // unused request code and the occasional stuffed window.
  task automatic random_phase(int budget, bit force_stuff);
    int stop_at;
    int kind;
    int len;
    stop_at = items_sent + budget;
    if (force_stuff) stuff_window();
    while (items_sent < stop_at) begin
      tx_no_gaps = ($urandom_range(3) == 0);
      kind = $urandom_range(99);
      if (kind < 65) begin
        len = $urandom_range(3, 14);
        repeat (len) send_item(REQ_TRIGGER, pick_word());
      end else if (kind < 73) begin
        stuff_window();
      end else if (kind < 88) begin
        send_item($urandom_range(1) ? REQ_RESTART : REQ_RESTART_LOW, pick_word());
      end else begin
        send_item(2'($urandom_range(3)), pick_word());
      end
    end
    tx_no_gaps = 1'b0;
  endtask

  // Result side: ready drops for short random stalls, sometimes long ones,
  // and stays high through steady stretches. A hold-off request from the
  // stimulus forces one long stall that backs the block up to its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
        steady_left  = 0;
      end else if (stall_left == 0 && steady_left == 0) begin
        rx_pick = $urandom_range(99);
        if (rx_pick < 30) stall_left = $urandom_range(1, 3);
        else if (rx_pick < 36) stall_left = $urandom_range(6, 30);
        else if (rx_pick < 40) steady_left = $urandom_range(20, 80);
      end
      if (steady_left > 0) steady_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result beat goes straight to the tracker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.beam_select       = out_ch.beam_select;
      seen.drive_valid       = out_ch.drive_valid;
      seen.drive_word        = out_ch.drive_word;
      seen.sample_average    = out_ch.sample_average;
      seen.reference_average = out_ch.reference_average;
      seen.sample_updated    = out_ch.sample_updated;
      seen.reference_updated = out_ch.reference_updated;
      seen.cycle_position    = out_ch.cycle_position;
      seen.last              = out_ch.last;
      tracker.check_beat(seen);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d result beats still owed", $time,
               quiet_cycles, tracker.pending());
      $display("chopper_beam_sequencer_averager test failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] steps_val;
    logic [CFG_DATA_W-1:0] dir_val;
    int                    ph;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_TRIGGER;
    in_ch.adc_word = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset settings of six steps upward. Walk to the
    // start of the sample window with all-zero and all-one words, restart
    // with one word already summed, send the unused request code, then walk a
    // whole window of full-scale words: six of them in one sum, so the sample
    // average clips. Carry on through the first motor position and the beam
    // going high, and finish with the restart that also drives the beam low.
    send_item(REQ_TRIGGER, '0);
    send_item(REQ_TRIGGER, FULL_SCALE);
    repeat (4) send_item(REQ_TRIGGER, pick_word());
    send_item(REQ_TRIGGER, FULL_SCALE);
    send_item(REQ_RESTART, 16'h5A5A);
    send_item(REQ_UNUSED, 16'hA5A5);
    repeat (11) send_item(REQ_TRIGGER, FULL_SCALE);
    send_item(REQ_TRIGGER, '0);
    send_item(REQ_TRIGGER, '0);
    send_item(REQ_RESTART_LOW, FULL_SCALE);

    // Random phases, each under its own register settings. Settings change
    // only once the block has delivered every owed beat, which is also where
    // the stimulus pauses until the result side has caught up.
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          steps_val = 4'd15;  // above the limit: saturates to eight steps
          dir_val   = 4'hE;   // only bit 0 counts: downward
        end
        1: begin
          steps_val = 4'd0;   // motor positions issue no drive word
          dir_val   = 4'h1;
        end
        2: begin
          steps_val = MAX_STEPS;
          dir_val   = 4'h0;
        end
        3: begin
          steps_val = 4'd1;
          dir_val   = 4'hF;
        end
        default: begin
          steps_val = CFG_DATA_W'($urandom_range(15));
          dir_val   = CFG_DATA_W'($urandom_range(15));
        end
      endcase
      write_reg(REG_CHOPPER_STEPS, steps_val);
      write_reg(REG_CHOPPER_FORWARD, dir_val);
      cfg_we <= 1'b0;
      settings++;

      // In the second phase the result side holds off for a long stretch
      // while requests keep coming back to back, so the queue fills and the
      // input stalls; the stimulus then waits for the block to empty.
      if (ph == 1) begin
        hold_off_req = 1'b1;
        tx_no_gaps   = 1'b1;
        repeat (12) send_item(REQ_TRIGGER, pick_word());
        tx_no_gaps   = 1'b0;
        drain();
      end
      random_phase(RANDOM_ITEMS / PHASES, ph == 2);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d register settings and checked %0d result beats,",
             tracker.requests, settings, tracker.beats);
    $display("including %0d drive words, %0d sample and %0d reference averages (%0d clipped).",
             tracker.drive_words, tracker.sample_avgs, tracker.reference_avgs,
             tracker.clipped_avgs);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("chopper_beam_sequencer_averager test passed");
    end else begin
      $display("%0d mismatches, %0d result beats never arrived", tracker.errors,
               tracker.pending());
      $display("chopper_beam_sequencer_averager test failed");
    end
    $finish;
  end

endmodule
